>>> rtl/spct_pkg.sv
// ----------------------------------------------------------------------------
// spct_pkg
// Shared widths, constants and sideband types for the sphere pair
// time-of-impact pipeline.
// ----------------------------------------------------------------------------
package spct_pkg;

  localparam int IN_W      = 24;   // input coordinate width
  localparam int D_W       = 25;   // difference of two coordinates
  localparam int P_W       = 50;   // signed product of two differences
  localparam int SQ_W      = 49;   // nonnegative square of a difference
  localparam int RAD_W     = 23;   // radius register width
  localparam int R4_W      = 48;   // 4 * radius^2
  localparam int A_W       = 50;   // a = dv.dv
  localparam int H_W       = 51;   // h = dp.dv, signed
  localparam int C_W       = 51;   // c = dp.dp - 4r^2, signed
  localparam int HALF_W    = 26;   // partial product operand width
  localparam int WIDE_W    = 104;  // full width of the wide products
  localparam int DISC_W    = 100;  // discriminant width
  localparam int ROOT_W    = DISC_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int N_W       = 53;   // -h - root, signed
  localparam int MAG_W     = 51;   // magnitude of -h - root
  localparam int TIME_FRAC = 16;
  localparam int Q_W       = 32;   // quotient bits produced by the divider
  localparam int SAT_W     = A_W + TIME_FRAC;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(4096);
  localparam logic [Q_W-1:0]   TIME_MAX   = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0]   TIME_MIN   = 32'h8000_0000;

  // sideband that rides along the square root chain
  typedef struct packed {
    logic                  no_hit;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
  } sq_side_t;

  // sideband that rides along the divider chain
  typedef struct packed {
    logic           no_hit;
    logic           neg;
    logic           sat;
    logic [A_W-1:0] a;
  } div_side_t;

endpackage

>>> rtl/spct_front.sv
// ----------------------------------------------------------------------------
// spct_front
// Differences, dot products, wide partial products and discriminant, in six
// register stages.
// ----------------------------------------------------------------------------
module spct_front import spct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [IN_W-1:0] p1_i [3],
  input  logic signed [IN_W-1:0] p2_i [3],
  input  logic signed [IN_W-1:0] v1_i [3],
  input  logic signed [IN_W-1:0] v2_i [3],
  input  logic [RAD_W-1:0]      radius_i,
  output logic                  valid_o,
  output logic [DISC_W-1:0]     disc_o,
  output sq_side_t              side_o
);

  logic ld1;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // stage 1 may fill a bubble even while the rest is held
  assign ld1        = adv_i | ~v1_q;
  assign in_ready_o = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      if (adv_i) begin
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
        v6_q <= v5_q;
      end
    end
  end

  // stage 1: differences and contact distance squared
  logic signed [D_W-1:0] dp_d [3], dv_d [3];
  logic signed [D_W-1:0] dp_q [3], dv_q [3];
  logic [2*RAD_W-1:0]    rsq;
  logic [R4_W-1:0]       r4_d, r4_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dp_d[k] = D_W'(p1_i[k]) - D_W'(p2_i[k]);
      dv_d[k] = D_W'(v1_i[k]) - D_W'(v2_i[k]);
    end
    rsq  = (2*RAD_W)'(radius_i) * (2*RAD_W)'(radius_i);
    r4_d = {rsq, 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      dp_q <= dp_d;
      dv_q <= dv_d;
      r4_q <= r4_d;
    end
  end

  // stage 2: per-axis products
  logic signed [P_W-1:0] sq_p [3], hp_p [3], dd_p [3];
  logic [SQ_W-1:0]       sq_q [3], dd_q [3];
  logic signed [P_W-1:0] hp_q [3];
  logic [R4_W-1:0]       r4_2q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_p[k] = dv_q[k] * dv_q[k];
      hp_p[k] = dp_q[k] * dv_q[k];
      dd_p[k] = dp_q[k] * dp_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= sq_p[k][SQ_W-1:0];
        dd_q[k] <= dd_p[k][SQ_W-1:0];
        hp_q[k] <= hp_p[k];
      end
      r4_2q <= r4_q;
    end
  end

  // stage 3: dot products
  logic [A_W-1:0]        a_d, a_q;
  logic signed [H_W-1:0] h_d, h_q;
  logic [A_W-1:0]        dd_sum;
  logic signed [C_W-1:0] c_d, c_q;

  always_comb begin
    a_d    = A_W'(sq_q[0]) + A_W'(sq_q[1]) + A_W'(sq_q[2]);
    h_d    = H_W'(hp_q[0]) + H_W'(hp_q[1]) + H_W'(hp_q[2]);
    dd_sum = A_W'(dd_q[0]) + A_W'(dd_q[1]) + A_W'(dd_q[2]);
    c_d    = $signed(C_W'(dd_sum)) - $signed(C_W'(r4_2q));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q <= a_d;
      h_q <= h_d;
      c_q <= c_d;
    end
  end

  // stage 4: split magnitudes and form partial products
  logic [2*HALF_W-1:0] hm, am, cm;
  logic [2*HALF_W-1:0] hhh_d, hhl_d, hll_d, ahch_d, ahcl_d, alch_d, alcl_d;
  logic [2*HALF_W-1:0] hhh_q, hhl_q, hll_q, ahch_q, ahcl_q, alch_q, alcl_q;
  logic                  cneg4_q, zero4_q;
  logic signed [H_W-1:0] h4_q;
  logic [A_W-1:0]        a4_q;

  always_comb begin
    hm     = h_q[H_W-1] ? (2*HALF_W)'(-h_q) : (2*HALF_W)'(h_q);
    cm     = c_q[C_W-1] ? (2*HALF_W)'(-c_q) : (2*HALF_W)'(c_q);
    am     = (2*HALF_W)'(a_q);
    hhh_d  = hm[2*HALF_W-1:HALF_W] * hm[2*HALF_W-1:HALF_W];
    hhl_d  = hm[2*HALF_W-1:HALF_W] * hm[HALF_W-1:0];
    hll_d  = hm[HALF_W-1:0] * hm[HALF_W-1:0];
    ahch_d = am[2*HALF_W-1:HALF_W] * cm[2*HALF_W-1:HALF_W];
    ahcl_d = am[2*HALF_W-1:HALF_W] * cm[HALF_W-1:0];
    alch_d = am[HALF_W-1:0] * cm[2*HALF_W-1:HALF_W];
    alcl_d = am[HALF_W-1:0] * cm[HALF_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hhh_q   <= hhh_d;
      hhl_q   <= hhl_d;
      hll_q   <= hll_d;
      ahch_q  <= ahch_d;
      ahcl_q  <= ahcl_d;
      alch_q  <= alch_d;
      alcl_q  <= alcl_d;
      cneg4_q <= c_q[C_W-1];
      zero4_q <= (a_q == '0);
      h4_q    <= h_q;
      a4_q    <= a_q;
    end
  end

  // stage 5: assemble h^2 and a*|c|
  logic [WIDE_W-1:0]     h2_d, ac_d, h2_q, ac_q;
  logic                  cneg5_q, zero5_q;
  logic signed [H_W-1:0] h5_q;
  logic [A_W-1:0]        a5_q;

  always_comb begin
    h2_d = (WIDE_W'(hhh_q) << (2*HALF_W)) + (WIDE_W'(hhl_q) << (HALF_W+1))
         + WIDE_W'(hll_q);
    ac_d = (WIDE_W'(ahch_q) << (2*HALF_W))
         + ((WIDE_W'(ahcl_q) + WIDE_W'(alch_q)) << HALF_W) + WIDE_W'(alcl_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      h2_q    <= h2_d;
      ac_q    <= ac_d;
      cneg5_q <= cneg4_q;
      zero5_q <= zero4_q;
      h5_q    <= h4_q;
      a5_q    <= a4_q;
    end
  end

  // stage 6: discriminant and miss detection
  logic [WIDE_W-1:0] disc_w;
  logic              miss;
  logic [DISC_W-1:0] disc_q;
  sq_side_t          side_q;

  always_comb begin
    disc_w = cneg5_q ? (h2_q + ac_q) : (h2_q - ac_q);
    miss   = zero5_q | (~cneg5_q & (h2_q < ac_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      disc_q        <= disc_w[DISC_W-1:0];
      side_q.no_hit <= miss;
      side_q.h      <= h5_q;
      side_q.a      <= a5_q;
    end
  end

  assign valid_o = v6_q;
  assign disc_o  = disc_q;
  assign side_o  = side_q;

endmodule

>>> rtl/spct_sqrt.sv
// ----------------------------------------------------------------------------
// spct_sqrt
// Floor square root of the discriminant, one root bit per register stage.
// ----------------------------------------------------------------------------
module spct_sqrt import spct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [DISC_W-1:0] disc_i,
  input  sq_side_t          side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output sq_side_t          side_o
);

  logic              v_q    [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [DISC_W-1:0] d_q    [ROOT_W];
  sq_side_t          side_q [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              v_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [DISC_W-1:0] d_p;
    sq_side_t          side_p;
    logic [REM_W+1:0]  rem_sh, trial, rem_n;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_p    = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign d_p    = disc_i;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[i-1];
      assign rem_p  = rem_q[i-1];
      assign root_p = root_q[i-1];
      assign d_p    = d_q[i-1];
      assign side_p = side_q[i-1];
    end

    // try setting the next root bit
    always_comb begin
      rem_sh = {rem_p, d_p[DISC_W-1 -: 2]};
      trial  = {2'b00, root_p, 2'b01};
      ge     = (rem_sh >= trial);
      rem_n  = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (adv_i) begin
        v_q[i] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i]  <= rem_n[REM_W-1:0];
        root_q[i] <= {root_p[ROOT_W-2:0], ge};
        d_q[i]    <= {d_p[DISC_W-3:0], 2'b00};
        side_q[i] <= side_p;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

>>> rtl/spct_div.sv
// ----------------------------------------------------------------------------
// spct_div
// Restoring divider: |n| * 2^16 / a, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module spct_div import spct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [MAG_W-1:0] mag_i,
  input  div_side_t        side_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o,
  output div_side_t        side_o
);

  logic            v_q    [Q_W];
  logic [A_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]  bits_q [Q_W];
  logic [Q_W-1:0]  quot_q [Q_W];
  div_side_t       side_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic           v_p;
    logic [A_W-1:0] rem_p;
    logic [Q_W-1:0] bits_p, quot_p;
    div_side_t      side_p;
    logic [A_W:0]   rem_sh, rem_n;
    logic           ge;

    if (i == 0) begin : g_first
      // the integer part above the quotient window seeds the remainder
      assign v_p    = valid_i;
      assign rem_p  = A_W'(mag_i[MAG_W-1:TIME_FRAC]);
      assign bits_p = {mag_i[TIME_FRAC-1:0], {(Q_W-TIME_FRAC){1'b0}}};
      assign quot_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[i-1];
      assign rem_p  = rem_q[i-1];
      assign bits_p = bits_q[i-1];
      assign quot_p = quot_q[i-1];
      assign side_p = side_q[i-1];
    end

    // shift in one dividend bit, subtract when it fits
    always_comb begin
      rem_sh = {rem_p, bits_p[Q_W-1]};
      ge     = (rem_sh >= {1'b0, side_p.a});
      rem_n  = ge ? (rem_sh - {1'b0, side_p.a}) : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (adv_i) begin
        v_q[i] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i]  <= rem_n[A_W-1:0];
        bits_q[i] <= {bits_p[Q_W-2:0], 1'b0};
        quot_q[i] <= {quot_p[Q_W-2:0], ge};
        side_q[i] <= side_p;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quot_o  = quot_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

>>> rtl/sphere_pair_collision_time.sv
// ----------------------------------------------------------------------------
// sphere_pair_collision_time
// Earliest contact time of two equal spheres moving at constant velocity.
//
//   channel  signals                          handshake
//   in       first/second pos/vel x,y,z       in_valid_i / in_ready_o
//   out      hit_time_o, no_hit_o, time_sat.  out_valid_o / out_ready_i
//   cfg      cfg_wdata_i (radius)             cfg_we_i, no wait
//
// One pair enters per cycle while the output is not held; the pipe has 90
// register stages: 6 front stages, 50 square root stages (one root bit each),
// one stage for the numerator, 32 divider stages (one quotient bit each), and
// the output register. Reset clears every valid bit and loads radius 4096.
// A held output freezes the whole pipe; the first stage still fills a bubble.
// ----------------------------------------------------------------------------
module sphere_pair_collision_time import spct_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [RAD_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  first_pos_x_i,
  input  logic signed [IN_W-1:0]  first_pos_y_i,
  input  logic signed [IN_W-1:0]  first_pos_z_i,
  input  logic signed [IN_W-1:0]  second_pos_x_i,
  input  logic signed [IN_W-1:0]  second_pos_y_i,
  input  logic signed [IN_W-1:0]  second_pos_z_i,
  input  logic signed [IN_W-1:0]  first_vel_x_i,
  input  logic signed [IN_W-1:0]  first_vel_y_i,
  input  logic signed [IN_W-1:0]  first_vel_z_i,
  input  logic signed [IN_W-1:0]  second_vel_x_i,
  input  logic signed [IN_W-1:0]  second_vel_y_i,
  input  logic signed [IN_W-1:0]  second_vel_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [Q_W-1:0]   hit_time_o,
  output logic                    no_hit_o,
  output logic                    time_saturated_o
);

  logic [RAD_W-1:0] radius_q;
  logic             adv;

  // radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // advance the pipe unless a result is held
  assign adv = ~out_valid_o | out_ready_i;

  logic signed [IN_W-1:0] p1 [3], p2 [3], v1 [3], v2 [3];

  assign p1[0] = first_pos_x_i;
  assign p1[1] = first_pos_y_i;
  assign p1[2] = first_pos_z_i;
  assign p2[0] = second_pos_x_i;
  assign p2[1] = second_pos_y_i;
  assign p2[2] = second_pos_z_i;
  assign v1[0] = first_vel_x_i;
  assign v1[1] = first_vel_y_i;
  assign v1[2] = first_vel_z_i;
  assign v2[0] = second_vel_x_i;
  assign v2[1] = second_vel_y_i;
  assign v2[2] = second_vel_z_i;

  logic              fr_valid;
  logic [DISC_W-1:0] fr_disc;
  sq_side_t          fr_side;

  spct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .p1_i       (p1),
    .p2_i       (p2),
    .v1_i       (v1),
    .v2_i       (v2),
    .radius_i   (radius_q),
    .valid_o    (fr_valid),
    .disc_o     (fr_disc),
    .side_o     (fr_side)
  );

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  spct_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_valid),
    .disc_i  (fr_disc),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // numerator stage: n = -h - root, its magnitude and the overflow test
  logic signed [N_W-1:0] n_w;
  logic [MAG_W-1:0]      mag_w, mag_q;
  logic                  num_v_q;
  div_side_t             num_side_d, num_side_q;

  always_comb begin
    n_w   = -N_W'(sq_side.h) - $signed(N_W'(sq_root));
    mag_w = n_w[N_W-1] ? MAG_W'(-n_w) : MAG_W'(n_w);
    num_side_d.no_hit = sq_side.no_hit;
    num_side_d.neg    = n_w[N_W-1];
    num_side_d.sat    = (SAT_W'(mag_w) >= {sq_side.a, {TIME_FRAC{1'b0}}});
    num_side_d.a      = sq_side.a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_v_q <= 1'b0;
    end else if (adv) begin
      num_v_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q      <= mag_w;
      num_side_q <= num_side_d;
    end
  end

  logic           dv_valid;
  logic [Q_W-1:0] dv_quot;
  div_side_t      dv_side;

  spct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (num_v_q),
    .mag_i   (mag_q),
    .side_i  (num_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // sign, clamp and miss handling into the output register
  logic [Q_W-1:0] time_d;
  logic           sat_d, out_v_q, no_hit_q, sat_q;
  logic [Q_W-1:0] time_q;

  always_comb begin
    time_d = '0;
    sat_d  = 1'b0;
    priority if (dv_side.no_hit) begin
      time_d = '0;
      sat_d  = 1'b0;
    end else if (dv_side.sat) begin
      time_d = dv_side.neg ? TIME_MIN : TIME_MAX;
      sat_d  = 1'b1;
    end else if (!dv_side.neg) begin
      sat_d  = (dv_quot > TIME_MAX);
      time_d = sat_d ? TIME_MAX : dv_quot;
    end else begin
      sat_d  = (dv_quot > TIME_MIN);
      time_d = sat_d ? TIME_MIN : (Q_W'(0) - dv_quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      time_q   <= time_d;
      no_hit_q <= dv_side.no_hit;
      sat_q    <= sat_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign hit_time_o       = $signed(time_q);
  assign no_hit_o         = no_hit_q;
  assign time_saturated_o = sat_q;

`ifndef SYNTHESIS
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_hit_o |-> hit_time_o == '0 && !time_saturated_o)
    else $error("miss result carries a time");

  a_sat_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && time_saturated_o |->
      ($unsigned(hit_time_o) == TIME_MAX || $unsigned(hit_time_o) == TIME_MIN))
    else $error("clamped time not at a range end");

  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

  a_hold_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_valid) && $stable(dv_quot))
    else $error("divider tail moved during a stall");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sphere pair time-of-impact pipeline. A driver
// streams queued sphere pairs in random bursts, a monitor stalls the result
// channel on its own pattern and compares every transfer against an exact
// wide-integer prediction of the earlier contact time.
// ----------------------------------------------------------------------------
module tb import spct_pkg::*; ();

  localparam int LATENCY   = 90;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 500;

  typedef struct {
    logic signed [IN_W-1:0] f[12];
  } pair_t;

  typedef struct {
    logic signed [31:0] hit_time;
    logic               no_hit;
    logic               sat;
  } impact_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [RAD_W-1:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o;
  logic signed [IN_W-1:0] fld[12];
  logic out_valid_o, out_ready_i;
  logic signed [Q_W-1:0] hit_time_o;
  logic no_hit_o, time_saturated_o;

  pair_t   pending_pairs[$];
  impact_t expected_impacts[$];
  logic [RAD_W-1:0] radius_q;
  int  errors;
  int  idle_cycles;
  int  burst_left, gap_left;
  int  stall_phase;
  bit  stall_mode;
  pair_t cur_pair;

  sphere_pair_collision_time dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .first_pos_x_i(fld[0]), .first_pos_y_i(fld[1]), .first_pos_z_i(fld[2]),
    .second_pos_x_i(fld[3]), .second_pos_y_i(fld[4]), .second_pos_z_i(fld[5]),
    .first_vel_x_i(fld[6]), .first_vel_y_i(fld[7]), .first_vel_z_i(fld[8]),
    .second_vel_x_i(fld[9]), .second_vel_y_i(fld[10]), .second_vel_z_i(fld[11]),
    .out_valid_o, .out_ready_i, .hit_time_o, .no_hit_o, .time_saturated_o
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // floor square root of a 100 bit value
  function automatic logic [49:0] isqrt(logic [127:0] d);
    logic [49:0] s;
    logic [49:0] cand;
    s = '0;
    for (int b = 49; b >= 0; b--) begin
      cand = s | (50'd1 << b);
      if ({78'd0, cand} * {78'd0, cand} <= d) s = cand;
    end
    return s;
  endfunction

  // earliest contact time for one pair at the current radius
  function automatic impact_t contact_time(pair_t p);
    impact_t r;
    logic signed [127:0] dp[3], dv[3];
    logic signed [127:0] a, h, c, dd, disc, n, mag, q;
    logic [49:0] root;
    a = 0; h = 0; dd = 0;
    for (int k = 0; k < 3; k++) begin
      dp[k] = 128'(p.f[k]) - 128'(p.f[3+k]);
      dv[k] = 128'(p.f[6+k]) - 128'(p.f[9+k]);
      a  += dv[k] * dv[k];
      h  += dp[k] * dv[k];
      dd += dp[k] * dp[k];
    end
    c = dd - 4 * $signed({105'd0, radius_q}) * $signed({105'd0, radius_q});
    r.hit_time = 0; r.no_hit = 1'b1; r.sat = 1'b0;
    if (a == 0) return r;
    disc = h * h - a * c;
    if (disc < 0) return r;
    root = isqrt(disc);
    n = -h - $signed({78'd0, root});
    mag = (n < 0) ? -n : n;
    q = (mag <<< 16) / a;
    r.no_hit = 1'b0;
    if (n >= 0) begin
      if (q > 128'sh7FFFFFFF) begin
        r.hit_time = 32'h7FFFFFFF; r.sat = 1'b1;
      end else begin
        r.hit_time = q[31:0];
      end
    end else begin
      if (q > 128'sh80000000) begin
        r.hit_time = 32'h80000000; r.sat = 1'b1;
      end else begin
        r.hit_time = -q[31:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic logic signed [IN_W-1:0] rand_coord(int mode);
    case (mode)
      0: return IN_W'($urandom);
      1: return IN_W'($signed(24'($urandom_range(0, 8192))) - 4096);
      default: return IN_W'($signed(24'($urandom_range(0, 1 << 17))) - (1 << 16));
    endcase
  endfunction

  // random pair in one of three coordinate ranges, some with equal velocities
  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++)
      p.f[k] = rand_coord(mode < 2 ? 0 : (mode < 6 ? 2 : 1));
    if (mode == 9) for (int k = 0; k < 3; k++) p.f[9+k] = p.f[6+k];
    return p;
  endfunction

  function automatic pair_t fill_pair(logic signed [IN_W-1:0] v);
    pair_t p;
    for (int k = 0; k < 12; k++) p.f[k] = v;
    return p;
  endfunction

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      for (int k = 0; k < 12; k++) fld[k] <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        expected_impacts = {expected_impacts, contact_time(cur_pair)};
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        cur_pair = pending_pairs.pop_front();
        for (int k = 0; k < 12; k++) fld[k] <= cur_pair.f[k];
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: stall pattern and result check
  always @(posedge clk_i or negedge rst_ni) begin
    impact_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
      stall_mode <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_phase <= $urandom_range(8, 120);
        stall_mode <= 1'($urandom_range(0, 1));
      end else begin
        stall_phase <= stall_phase - 1;
      end
      out_ready_i <= stall_mode ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (out_valid_o && out_ready_i) begin
        if (expected_impacts.size() == 0) begin
          report_mismatch("unexpected result", hit_time_o, 0);
        end else begin
          e = expected_impacts.pop_front();
          if (hit_time_o !== e.hit_time) report_mismatch("hit_time", hit_time_o, e.hit_time);
          if (no_hit_o !== e.no_hit) report_mismatch("no_hit", no_hit_o, e.no_hit);
          if (time_saturated_o !== e.sat)
            report_mismatch("time_saturated", time_saturated_o, e.sat);
        end
      end
    end
  end

  // watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_MAX) begin
      $display("sphere_pair_collision_time regression: fail");
      $finish;
    end
  end

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid_i || expected_impacts.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [RAD_W-1:0] r);
    @(posedge clk_i);
    cfg_wdata_i <= r;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    radius_q = r;
  endtask

  initial begin
    pair_t p;
    logic [RAD_W-1:0] radii[5];
    errors = 0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    radius_q = RADIUS_RST;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset radius, extremes, zero motion, miss, saturation
    pending_pairs = {pending_pairs, fill_pair(0)};
    pending_pairs = {pending_pairs, fill_pair(24'sh7FFFFF)};
    p = fill_pair(0); p.f[0] = 24'sh7FFFFF; p.f[3] = 24'sh800000;
    pending_pairs = {pending_pairs, p};
    p.f[6] = 24'sh800000; p.f[9] = 24'sh7FFFFF;
    pending_pairs = {pending_pairs, p};
    p = fill_pair(0); p.f[0] = -24'sd40960; p.f[6] = 24'sd4096;
    pending_pairs = {pending_pairs, p};
    p = fill_pair(0); p.f[0] = -24'sd40960; p.f[1] = 24'sd40960; p.f[6] = 24'sd4096;
    pending_pairs = {pending_pairs, p};
    p = fill_pair(0); p.f[0] = 24'sh800000; p.f[6] = 24'sd1;
    pending_pairs = {pending_pairs, p};
    p = fill_pair(0); p.f[0] = 24'sh7FFFFF; p.f[6] = 24'sd1;
    pending_pairs = {pending_pairs, p};
    p = fill_pair(0); p.f[6] = 24'sd1;
    pending_pairs = {pending_pairs, p};
    for (int k = 0; k < 12; k++) begin
      p = fill_pair(0); p.f[k] = 24'sh800000;
      pending_pairs = {pending_pairs, p};
    end
    drain();

    // random phases over several radii, extremes included
    radii = '{23'd0, 23'h7FFFFF, 23'd4096, 23'd300000, 23'd1};
    foreach (radii[i]) begin
      write_radius(radii[i]);
      for (int j = 0; j < N_RANDOM / 5; j++) pending_pairs = {pending_pairs, random_pair()};
      drain();
    end

    if (errors == 0) begin
      $display("sphere_pair_collision_time regression: pass");
    end else begin
      $display("sphere_pair_collision_time regression: fail");
    end
    $finish;
  end

endmodule
